/* rtl/trp_pkg.sv */
// ----------------------------------------------------------------------------
// trp_pkg
// Types, constants and codes shared by the token repetition penalty unit.
// ----------------------------------------------------------------------------
package trp_pkg;

	localparam int LOGIT_W    = 32;
	localparam int TOKEN_W    = 16;
	localparam int OCC_W      = 11;
	localparam int OP_W       = 2;
	localparam int PEN_W      = 16;
	localparam int WIN_W      = 11;
	localparam int VOCAB_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int VOCAB_DEPTH_DEF   = 65536;
	localparam int FQ_DEPTH          = 4;
	localparam int OQ_DEPTH          = 2;

	localparam logic [PEN_W-1:0]   REPEAT_UNITY   = 16'd256;
	localparam logic [VOCAB_W-1:0] VOCAB_SIZE_RST = 17'h10000;
	localparam logic [OCC_W-1:0]   OCC_MAX        = 11'h7FF;

	typedef enum logic [OP_W-1:0] {
		OP_RECORD = 2'd0,
		OP_ADJUST = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPEAT = 3'd0,
		CFG_FREQ   = 3'd1,
		CFG_PRES   = 3'd2,
		CFG_WINDOW = 3'd3,
		CFG_VOCAB  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_ADJUST,
		KIND_CLEAR
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REC_OLD,
		ST_REC_OLDCNT,
		ST_REC_DEC,
		ST_REC_NEW,
		ST_REC_INC,
		ST_AD_START,
		ST_AD_CNT,
		ST_AD_SCAN,
		ST_AD_MUL,
		ST_AD_DIV,
		ST_AD_SCALE,
		ST_AD_SUM,
		ST_AD_OUT
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [TOKEN_W-1:0]        token;
		logic signed [LOGIT_W-1:0] logit_value;
	} req_t;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] adjusted_logit;
		logic [TOKEN_W-1:0]        logit_token;
		logic [OCC_W-1:0]          occurrences;
		logic                      saturated;
	} res_t;

	typedef struct packed {
		kind_t                     kind;
		logic [TOKEN_W-1:0]        token;
		logic signed [LOGIT_W-1:0] logit;
	} item_t;

	typedef struct packed {
		logic [PEN_W-1:0]        repeat_penalty;
		logic signed [PEN_W-1:0] freq_pen;
		logic signed [PEN_W-1:0] pres_pen;
		logic [WIN_W-1:0]        window_length;
		logic [VOCAB_W-1:0]      vocab_size;
	} cfg_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} fq_head_t;

endpackage

/* rtl/trp_front.sv */
// ----------------------------------------------------------------------------
// trp_front
// Request intake: classifies each request and queues the ones with work.
// ----------------------------------------------------------------------------
module trp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  trp_pkg::req_t    request,
	input  logic             hold,
	output trp_pkg::fq_head_t head,
	input  logic             item_pop
);

	localparam int PW = $clog2(trp_pkg::FQ_DEPTH);

	trp_pkg::item_t q_mem [trp_pkg::FQ_DEPTH];
	logic [PW-1:0]  rd_q;
	logic [PW-1:0]  wr_q;
	logic [PW:0]    cnt_q;
	logic           keep;
	trp_pkg::item_t new_item;
	logic           wr_en;
	logic           rd_en;

	always_comb begin
		keep          = 1'b1;
		new_item.kind = trp_pkg::KIND_RECORD;
		unique case (request.operation)
			trp_pkg::OP_RECORD: new_item.kind = trp_pkg::KIND_RECORD;
			trp_pkg::OP_ADJUST: new_item.kind = trp_pkg::KIND_ADJUST;
			trp_pkg::OP_CLEAR:  new_item.kind = trp_pkg::KIND_CLEAR;
			default:            keep = 1'b0;
		endcase
		new_item.token = request.token;
		new_item.logit = request.logit_value;
	end

	assign full       = (cnt_q == (PW+1)'(trp_pkg::FQ_DEPTH)) || hold;
	assign wr_en      = push && !full && keep;
	assign head.valid = cnt_q != '0;
	assign head.item  = q_mem[rd_q];
	assign rd_en      = item_pop && head.valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + PW'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

/* rtl/trp_back.sv */
// ----------------------------------------------------------------------------
// trp_back
// Execution sequencer: history ring, count table, window scan and penalty
// arithmetic with a bit-serial divider.
// ----------------------------------------------------------------------------
module trp_back #(
	parameter int HISTORY_DEPTH = trp_pkg::HISTORY_DEPTH_DEF,
	parameter int VOCAB_DEPTH   = trp_pkg::VOCAB_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trp_pkg::cfg_t     cfg,
	input  trp_pkg::fq_head_t head,
	output logic              item_pop,
	output logic              clearing,
	output logic              res_push,
	output trp_pkg::res_t     res,
	input  logic              res_room
);

	localparam int LW  = trp_pkg::LOGIT_W;
	localparam int PW  = trp_pkg::PEN_W;
	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int HW  = $clog2(HISTORY_DEPTH + 1);
	localparam int TW  = $clog2(VOCAB_DEPTH);
	localparam int CW  = (HW > trp_pkg::WIN_W) ? HW : trp_pkg::WIN_W;
	localparam int VW  = LW + 20;
	localparam int MW  = LW + PW + 1;
	localparam int FW  = PW + HW + 1;
	localparam int DW  = LW + 8;
	localparam int DCW = $clog2(DW + 1);

	logic [trp_pkg::TOKEN_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [HW-1:0]               cnt_mem  [VOCAB_DEPTH];

	logic                        hist_we;
	logic [AW-1:0]               hist_ra;
	logic [trp_pkg::TOKEN_W-1:0] hist_rd;
	logic                        cnt_we;
	logic [TW-1:0]               cnt_wa;
	logic [HW-1:0]               cnt_wd;
	logic [TW-1:0]               cnt_ra;
	logic [HW-1:0]               cnt_rd;

	trp_pkg::state_t state_q, state_d;

	logic [TW-1:0]               clr_q;
	logic [AW-1:0]               wp_q;
	logic [HW-1:0]               fill_q;
	logic [trp_pkg::TOKEN_W-1:0] tok_q;
	logic signed [LW-1:0]        logit_q;
	logic [trp_pkg::TOKEN_W-1:0] old_q;
	logic                        old_ok_q;
	logic [HW-1:0]               n_q;
	logic [AW-1:0]               scan_ptr_q;
	logic [CW-1:0]               scan_left_q;
	logic                        cmp_v_q;
	logic signed [MW-1:0]        mprod_q;
	logic signed [FW-1:0]        fprod_q;
	logic                        rp_on_q;
	logic [DW-1:0]               dq_q;
	logic [PW-1:0]               rem_q;
	logic [DCW-1:0]              dcnt_q;
	logic signed [VW-1:0]        v1_q;
	logic signed [VW-1:0]        acc_q;

	logic                 tok_ok;
	logic                 in_vocab;
	logic [CW-1:0]        win_c;
	logic                 win_cover;
	logic                 ring_full;
	logic [AW-1:0]        wp_next;
	logic [AW-1:0]        wp_prev;
	logic [AW-1:0]        ptr_prev;
	logic signed [MW-1:0] mprod_c;
	logic signed [FW-1:0] fprod_c;
	logic                 rp_on_c;
	logic [PW:0]          trial;
	logic                 ge;
	logic [PW-1:0]        rem_next;
	logic signed [MW-1:0] mbias;
	logic signed [MW-1:0] mscaled;
	logic signed [VW-1:0] v1_c;
	logic signed [VW-1:0] ft;
	logic signed [VW-1:0] pt;
	logic [VW-LW:0]       top_bits;
	logic                 ovf;

	// ---- memories ----
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= tok_q;
		end
		hist_rd <= hist_mem[hist_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd <= cnt_mem[cnt_ra];
	end

	// ---- shared conditions ----
	assign tok_ok    = 32'(tok_q) < VOCAB_DEPTH;
	assign in_vocab  = tok_ok && (trp_pkg::VOCAB_W'(tok_q) < cfg.vocab_size);
	assign win_c     = (cfg.window_length == '0
		|| CW'(cfg.window_length) > CW'(HISTORY_DEPTH))
		? CW'(HISTORY_DEPTH) : CW'(cfg.window_length);
	assign win_cover = win_c >= CW'(fill_q);
	assign ring_full = fill_q == HW'(HISTORY_DEPTH);
	assign wp_next   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign wp_prev   = (wp_q == '0) ? AW'(HISTORY_DEPTH - 1) : wp_q - AW'(1);
	assign ptr_prev  = (scan_ptr_q == '0) ? AW'(HISTORY_DEPTH - 1) : scan_ptr_q - AW'(1);

	assign mprod_c = MW'(logit_q) * MW'($signed({1'b0, cfg.repeat_penalty}));
	assign fprod_c = FW'(cfg.freq_pen) * FW'($signed({1'b0, n_q}));
	assign rp_on_c = (n_q != '0) && (cfg.repeat_penalty != trp_pkg::REPEAT_UNITY)
		&& (cfg.repeat_penalty != '0);

	assign trial    = {rem_q, dq_q[DW-1]};
	assign ge       = trial >= {1'b0, cfg.repeat_penalty};
	assign rem_next = ge ? PW'(trial - {1'b0, cfg.repeat_penalty}) : PW'(trial);

	assign mbias   = mprod_q[MW-1] ? mprod_q + MW'(255) : mprod_q;
	assign mscaled = mbias >>> 8;
	assign v1_c    = !rp_on_q ? VW'(logit_q)
		: (logit_q > 0) ? VW'($signed({1'b0, dq_q})) : VW'(mscaled);
	assign ft      = (n_q != '0) ? (VW'(fprod_q) <<< 8) : '0;
	assign pt      = (n_q != '0) ? (VW'(cfg.pres_pen) <<< 8) : '0;

	assign top_bits = acc_q[VW-1:LW-1];
	assign ovf      = !((&top_bits) || !(|top_bits));

	// ---- memory ports and handshakes ----
	always_comb begin
		hist_we = state_q == trp_pkg::ST_REC_NEW;
		hist_ra = (state_q == trp_pkg::ST_REC_OLD) ? wp_q : scan_ptr_q;
		cnt_ra  = (state_q == trp_pkg::ST_REC_OLDCNT) ? TW'(hist_rd) : TW'(tok_q);
		cnt_we  = 1'b0;
		cnt_wa  = TW'(tok_q);
		cnt_wd  = cnt_rd + HW'(1);
		unique case (state_q)
			trp_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
				cnt_wd = '0;
			end
			trp_pkg::ST_REC_DEC: begin
				cnt_we = old_ok_q && (cnt_rd != '0);
				cnt_wa = TW'(old_q);
				cnt_wd = cnt_rd - HW'(1);
			end
			trp_pkg::ST_REC_INC: begin
				cnt_we = tok_ok;
			end
			default: begin
			end
		endcase
	end

	assign item_pop = (state_q == trp_pkg::ST_IDLE) && head.valid;
	assign clearing = state_q == trp_pkg::ST_CLEAR;
	assign res_push = (state_q == trp_pkg::ST_AD_OUT) && res_room;

	always_comb begin
		res.adjusted_logit = ovf ? (acc_q[VW-1] ? {1'b1, {(LW-1){1'b0}}}
			: {1'b0, {(LW-1){1'b1}}}) : acc_q[LW-1:0];
		res.logit_token    = tok_q;
		res.occurrences    = (CW'(n_q) > CW'(trp_pkg::OCC_MAX))
			? trp_pkg::OCC_MAX : trp_pkg::OCC_W'(n_q);
		res.saturated      = ovf;
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trp_pkg::ST_CLEAR: begin
				if (clr_q == TW'(VOCAB_DEPTH - 1)) begin
					state_d = trp_pkg::ST_IDLE;
				end
			end
			trp_pkg::ST_IDLE: begin
				if (head.valid) begin
					unique case (head.item.kind)
						trp_pkg::KIND_RECORD:
							state_d = ring_full ? trp_pkg::ST_REC_OLD : trp_pkg::ST_REC_NEW;
						trp_pkg::KIND_ADJUST: state_d = trp_pkg::ST_AD_START;
						default:              state_d = trp_pkg::ST_CLEAR;
					endcase
				end
			end
			trp_pkg::ST_REC_OLD:    state_d = trp_pkg::ST_REC_OLDCNT;
			trp_pkg::ST_REC_OLDCNT: state_d = trp_pkg::ST_REC_DEC;
			trp_pkg::ST_REC_DEC:    state_d = trp_pkg::ST_REC_NEW;
			trp_pkg::ST_REC_NEW:    state_d = trp_pkg::ST_REC_INC;
			trp_pkg::ST_REC_INC:    state_d = trp_pkg::ST_IDLE;
			trp_pkg::ST_AD_START: begin
				priority if (!in_vocab) begin
					state_d = trp_pkg::ST_AD_MUL;
				end else if (win_cover) begin
					state_d = trp_pkg::ST_AD_CNT;
				end else begin
					state_d = trp_pkg::ST_AD_SCAN;
				end
			end
			trp_pkg::ST_AD_CNT: state_d = trp_pkg::ST_AD_MUL;
			trp_pkg::ST_AD_SCAN: begin
				if (scan_left_q == '0 && !cmp_v_q) begin
					state_d = trp_pkg::ST_AD_MUL;
				end
			end
			trp_pkg::ST_AD_MUL: begin
				state_d = (rp_on_c && logit_q > 0) ? trp_pkg::ST_AD_DIV : trp_pkg::ST_AD_SCALE;
			end
			trp_pkg::ST_AD_DIV: begin
				if (dcnt_q == DCW'(DW - 1)) begin
					state_d = trp_pkg::ST_AD_SCALE;
				end
			end
			trp_pkg::ST_AD_SCALE: state_d = trp_pkg::ST_AD_SUM;
			trp_pkg::ST_AD_SUM:   state_d = trp_pkg::ST_AD_OUT;
			trp_pkg::ST_AD_OUT: begin
				if (res_room) begin
					state_d = trp_pkg::ST_IDLE;
				end
			end
			default: state_d = trp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			cmp_v_q     <= 1'b0;
			scan_left_q <= '0;
		end else begin
			unique case (state_q)
				trp_pkg::ST_CLEAR: begin
					clr_q <= clr_q + TW'(1);
				end
				trp_pkg::ST_IDLE: begin
					if (head.valid && head.item.kind == trp_pkg::KIND_CLEAR) begin
						clr_q  <= '0;
						wp_q   <= '0;
						fill_q <= '0;
					end
				end
				trp_pkg::ST_REC_INC: begin
					wp_q <= wp_next;
					if (!ring_full) begin
						fill_q <= fill_q + HW'(1);
					end
				end
				trp_pkg::ST_AD_START: begin
					scan_left_q <= win_c;
					cmp_v_q     <= 1'b0;
				end
				trp_pkg::ST_AD_SCAN: begin
					if (scan_left_q != '0) begin
						scan_left_q <= scan_left_q - CW'(1);
						cmp_v_q     <= 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			trp_pkg::ST_IDLE: begin
				tok_q   <= head.item.token;
				logit_q <= head.item.logit;
			end
			trp_pkg::ST_REC_OLDCNT: begin
				old_q    <= hist_rd;
				old_ok_q <= 32'(hist_rd) < VOCAB_DEPTH;
			end
			trp_pkg::ST_AD_START: begin
				n_q        <= '0;
				scan_ptr_q <= wp_prev;
			end
			trp_pkg::ST_AD_CNT: begin
				n_q <= cnt_rd;
			end
			trp_pkg::ST_AD_SCAN: begin
				if (cmp_v_q && hist_rd == tok_q) begin
					n_q <= n_q + HW'(1);
				end
				if (scan_left_q != '0) begin
					scan_ptr_q <= ptr_prev;
				end
			end
			trp_pkg::ST_AD_MUL: begin
				mprod_q <= mprod_c;
				fprod_q <= fprod_c;
				rp_on_q <= rp_on_c;
				dq_q    <= {logit_q, 8'd0};
				rem_q   <= '0;
				dcnt_q  <= '0;
			end
			trp_pkg::ST_AD_DIV: begin
				dq_q   <= {dq_q[DW-2:0], ge};
				rem_q  <= rem_next;
				dcnt_q <= dcnt_q + DCW'(1);
			end
			trp_pkg::ST_AD_SCALE: begin
				v1_q <= v1_c;
			end
			trp_pkg::ST_AD_SUM: begin
				acc_q <= v1_q - ft - pt;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/trp_outq.sv */
// ----------------------------------------------------------------------------
// trp_outq
// Result queue between the sequencer and the consumer.
// ----------------------------------------------------------------------------
module trp_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  trp_pkg::res_t res_in,
	output logic          res_room,
	output logic          empty,
	input  logic          pop,
	output trp_pkg::res_t result
);

	localparam int PW = $clog2(trp_pkg::OQ_DEPTH);

	trp_pkg::res_t q_mem [trp_pkg::OQ_DEPTH];
	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [PW:0]   cnt_q;
	logic          wr_en;
	logic          rd_en;

	assign res_room = cnt_q != (PW+1)'(trp_pkg::OQ_DEPTH);
	assign empty    = cnt_q == '0;
	assign result   = q_mem[rd_q];
	assign wr_en    = res_push && res_room;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + PW'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

/* rtl/token_repetition_penalty_unit.sv */
// ----------------------------------------------------------------------------
// token_repetition_penalty_unit
// Repetition, frequency and presence penalty over a window of recent tokens.
//
// Requests enter through push/full: record a token, adjust a logit, or clear
// the history. Adjust requests produce one result each, read through
// empty/pop in request order; other requests produce none. Registers are to be
// written through cfg_valid/cfg_ready/cfg_index/cfg_data only while idle; the
// block itself does not enforce it. A four-entry request queue decouples
// intake from the sequencer. A record reads out and decrements the count of
// the oldest token once the ring is full, then writes and counts the new
// token. An adjust takes the count from the count table, or scans the window
// when it is shorter than the stored history; a token outside the vocabulary
// skips both, and a positive logit that is penalised is divided by the
// repetition penalty. The sequencer handles one request at a time.
// After reset, and after each clear request, the count table is swept over
// all VOCAB_DEPTH entries with full held high; configuration is still taken.
// A stalled consumer fills the two-entry result queue, then the sequencer
// holds, then the request queue fills and full rises.
// ----------------------------------------------------------------------------
module token_repetition_penalty_unit #(
	parameter int HISTORY_DEPTH = trp_pkg::HISTORY_DEPTH_DEF,
	parameter int VOCAB_DEPTH   = trp_pkg::VOCAB_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  trp_pkg::req_t                    request,
	output logic                             empty,
	input  logic                             pop,
	output trp_pkg::res_t                    result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [trp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	trp_pkg::cfg_t     cfg_q;
	trp_pkg::fq_head_t head;
	logic              item_pop;
	logic              clearing;
	logic              res_push;
	trp_pkg::res_t     res;
	logic              res_room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_penalty <= trp_pkg::REPEAT_UNITY;
			cfg_q.freq_pen       <= '0;
			cfg_q.pres_pen       <= '0;
			cfg_q.window_length  <= '0;
			cfg_q.vocab_size     <= trp_pkg::VOCAB_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				trp_pkg::CFG_REPEAT: cfg_q.repeat_penalty <= cfg_data[trp_pkg::PEN_W-1:0];
				trp_pkg::CFG_FREQ:   cfg_q.freq_pen       <= cfg_data[trp_pkg::PEN_W-1:0];
				trp_pkg::CFG_PRES:   cfg_q.pres_pen       <= cfg_data[trp_pkg::PEN_W-1:0];
				trp_pkg::CFG_WINDOW: cfg_q.window_length  <= cfg_data[trp_pkg::WIN_W-1:0];
				trp_pkg::CFG_VOCAB:  cfg_q.vocab_size     <= cfg_data[trp_pkg::VOCAB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	trp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.hold     (clearing),
		.head     (head),
		.item_pop (item_pop)
	);

	trp_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.VOCAB_DEPTH   (VOCAB_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.item_pop (item_pop),
		.clearing (clearing),
		.res_push (res_push),
		.res      (res),
		.res_room (res_room)
	);

	trp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_room (res_room),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* tb/token_repetition_penalty_unit_tb.sv */
// ----------------------------------------------------------------------------
// token_repetition_penalty_unit_tb
// Drives record, adjust, clear and unused requests through the queue ports
// under several register settings. A scoreboard class keeps its own token
// ring and count table and checks each adjusted logit field by field.
// ----------------------------------------------------------------------------
module token_repetition_penalty_unit_tb;

	localparam logic [trp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RING_DEPTH = 1024;
	localparam int STALL_LIMIT = 300000;
	localparam int TOK_W = trp_pkg::TOKEN_W;

	class penalty_scoreboard;
		int unsigned repeat_q8;
		int freq_q8;
		int pres_q8;
		int unsigned win_span;
		int unsigned vocab_limit;
		logic [TOK_W-1:0] ring[RING_DEPTH];
		int unsigned write_pos;
		int unsigned fill;
		int unsigned counts[65536];
		trp_pkg::res_t expected[$];
		int errors;

		function new();
			repeat_q8 = 256;
			freq_q8 = 0;
			pres_q8 = 0;
			win_span = 0;
			vocab_limit = 65536;
			errors = 0;
			clear_store();
		endfunction

		function void clear_store();
			foreach (counts[i]) counts[i] = 0;
			foreach (ring[i]) ring[i] = '0;
			write_pos = 0;
			fill = 0;
		endfunction

		function void configure(trp_pkg::cfg_idx_t idx, logic [trp_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				trp_pkg::CFG_REPEAT: repeat_q8 = d[15:0];
				trp_pkg::CFG_FREQ:   freq_q8 = $signed(d[15:0]);
				trp_pkg::CFG_PRES:   pres_q8 = $signed(d[15:0]);
				trp_pkg::CFG_WINDOW: win_span = d[10:0];
				trp_pkg::CFG_VOCAB:  vocab_limit = d[16:0];
				default: ;
			endcase
		endfunction

		function int unsigned window_count(logic [TOK_W-1:0] tok);
			int unsigned span;
			int unsigned n;
			if (tok >= vocab_limit) return 0;
			span = win_span;
			if (span == 0 || span > RING_DEPTH) span = RING_DEPTH;
			if (span >= fill) return counts[tok];
			n = 0;
			for (int unsigned i = 0; i < span; i++)
				if (ring[(write_pos + RING_DEPTH - 1 - i) % RING_DEPTH] == tok) n++;
			return n;
		endfunction

		function void note_request(trp_pkg::req_t r);
			longint v;
			int unsigned n;
			logic [TOK_W-1:0] old;
			trp_pkg::res_t e;
			case (r.operation)
				trp_pkg::OP_RECORD: begin
					if (fill >= RING_DEPTH) begin
						old = ring[write_pos];
						if (counts[old] > 0) counts[old]--;
					end else fill++;
					ring[write_pos] = r.token;
					counts[r.token]++;
					write_pos = (write_pos + 1) % RING_DEPTH;
				end
				trp_pkg::OP_CLEAR: clear_store();
				trp_pkg::OP_ADJUST: begin
					v = longint'(r.logit_value);
					n = window_count(r.token);
					e.saturated = 1'b0;
					if (n > 0) begin
						if (repeat_q8 != 256 && repeat_q8 != 0) begin
							if (v > 0) v = (v * 256) / longint'(repeat_q8);
							else v = (v * longint'(repeat_q8)) / 256;
						end
						v -= longint'(freq_q8) * longint'(n) * 256;
						v -= longint'(pres_q8) * 256;
					end
					if (v > 64'sd2147483647) begin
						v = 64'sd2147483647;
						e.saturated = 1'b1;
					end
					if (v < -64'sd2147483648) begin
						v = -64'sd2147483648;
						e.saturated = 1'b1;
					end
					e.adjusted_logit = v[31:0];
					e.logit_token = r.token;
					e.occurrences = (n > 2047) ? trp_pkg::OCC_MAX : n[trp_pkg::OCC_W-1:0];
					expected.insert(expected.size(), e);
				end
				default: ;
			endcase
		endfunction

		function void check_result(trp_pkg::res_t r);
			trp_pkg::res_t e;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", r);
				return;
			end
			e = expected.pop_front();
			if (r.adjusted_logit !== e.adjusted_logit || r.logit_token !== e.logit_token ||
			    r.occurrences !== e.occurrences || r.saturated !== e.saturated) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected %p, got %p", e, r);
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	trp_pkg::req_t request;
	logic empty;
	logic pop;
	trp_pkg::res_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [trp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [trp_pkg::CFG_DATA_W-1:0] cfg_data;

	penalty_scoreboard sb = new();
	bit quiet;
	bit clears_allowed;
	int clear_budget;
	int hold_cycles;
	int pop_gap;
	int idle_cycles;

	token_repetition_penalty_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		pop = 1'b0;
		pop_gap = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check_result(result);
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap--;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				pop <= 1'b0;
				pop_gap = $urandom_range(0, 10);
			end else pop <= 1'b1;
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) ||
			    (!push && sb.pending() == 0))
				idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_request(logic [trp_pkg::OP_W-1:0] op, logic [TOK_W-1:0] tok,
	                            logic [trp_pkg::LOGIT_W-1:0] logit);
		trp_pkg::req_t r;
		r.operation = op;
		r.token = tok;
		r.logit_value = logit;
		request <= r;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.note_request(r);
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic write_reg(trp_pkg::cfg_idx_t idx, int value);
		cfg_index <= idx;
		cfg_data <= value[trp_pkg::CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.configure(idx, value[trp_pkg::CFG_DATA_W-1:0]);
	endtask

	task automatic apply_settings(int rp, int fp, int pp, int win, int vocab);
		push <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		write_reg(trp_pkg::CFG_REPEAT, rp);
		write_reg(trp_pkg::CFG_FREQ, fp);
		write_reg(trp_pkg::CFG_PRES, pp);
		write_reg(trp_pkg::CFG_WINDOW, win);
		write_reg(trp_pkg::CFG_VOCAB, vocab);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TOK_W-1:0] pick_token();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 14) return TOK_W'($urandom_range(0, 23));
		if (k < 18) return TOK_W'($urandom_range(0, 65535));
		if (k == 18) return TOK_W'(sb.vocab_limit - 1);
		return TOK_W'(sb.vocab_limit);
	endfunction

	function automatic logic [trp_pkg::LOGIT_W-1:0] pick_logit();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return ($urandom_range(0, 4000) - 2000) <<< 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request(int record_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < record_pct) send_request(trp_pkg::OP_RECORD, pick_token(), $urandom);
		else if (r < 98) send_request(trp_pkg::OP_ADJUST, pick_token(), pick_logit());
		else if (r == 98 && clears_allowed && clear_budget > 0) begin
			clear_budget--;
			send_request(trp_pkg::OP_CLEAR, pick_token(), $urandom);
		end else send_request(OP_UNUSED, pick_token(), $urandom);
		sender_gap();
	endtask

	task automatic run_phase(int count, int record_pct);
		repeat (count) random_request(record_pct);
	endtask

	initial begin
		quiet = 1'b0;
		clears_allowed = 1'b0;
		clear_budget = 3;
		hold_cycles = 0;
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings(512, 64, -128, 0, 65536);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'd1000);
		send_request(trp_pkg::OP_RECORD, 16'd7, '0);
		send_request(trp_pkg::OP_RECORD, 16'd7, '1);
		send_request(trp_pkg::OP_RECORD, 16'hFFFF, '0);
		send_request(trp_pkg::OP_RECORD, 16'd0, '0);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'h7FFF_FFFF);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'h8000_0000);
		send_request(trp_pkg::OP_ADJUST, 16'd7, '0);
		send_request(trp_pkg::OP_ADJUST, 16'd7, '1);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'd1);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'h0001_0000);
		send_request(trp_pkg::OP_ADJUST, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(trp_pkg::OP_ADJUST, 16'd0, 32'h8000_0000);
		send_request(trp_pkg::OP_ADJUST, 16'd9, 32'h1234_5678);
		send_request(OP_UNUSED, 16'd7, '1);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'd77);
		send_request(trp_pkg::OP_CLEAR, 16'hFFFF, '1);
		send_request(trp_pkg::OP_ADJUST, 16'd7, 32'd5000);
		send_request(trp_pkg::OP_RECORD, 16'd7, '0);
		send_request(trp_pkg::OP_RECORD, 16'hFFFF, '0);
		send_request(trp_pkg::OP_ADJUST, 16'hFFFF, 32'hFFFF_0000);

		apply_settings(256, 0, 0, 0, 65536);
		clears_allowed = 1'b1;
		run_phase(150, 60);
		clears_allowed = 1'b0;

		apply_settings(65535, 32767, -32768, 1, 65536);
		hold_cycles = 400;
		repeat (40) send_request(trp_pkg::OP_ADJUST, TOK_W'($urandom_range(0, 23)),
		                         pick_logit());
		run_phase(110, 60);

		apply_settings(1, -32768, 32767, 2047, 16);
		run_phase(150, 80);

		apply_settings(0, 300, 100, 8, 0);
		run_phase(100, 80);

		apply_settings(384, -200, 50, 1024, 131071);
		run_phase(450, 95);

		apply_settings($urandom_range(1, 65535), $urandom_range(0, 65535) - 32768,
		               $urandom_range(0, 65535) - 32768, $urandom_range(1, 40),
		               $urandom_range(1, 65536));
		run_phase(150, 70);

		apply_settings(640, 20, 10, 700, 65536);
		run_phase(100, 50);

		apply_settings($urandom_range(1, 65535), $urandom_range(0, 65535) - 32768,
		               $urandom_range(0, 65535) - 32768, $urandom_range(0, 64), 65536);
		quiet = 1'b1;
		run_phase(250, 60);
		push <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		if (sb.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
rtl/trp_pkg.sv
rtl/trp_front.sv
rtl/trp_back.sv
rtl/trp_outq.sv
rtl/token_repetition_penalty_unit.sv
tb/token_repetition_penalty_unit_tb.sv
